// ===== rtl/vfg5_pkg.sv =====
// vfg5_pkg: widths, codes and row-operand selection for the 5-tet voxel gradient.
// Used by voxel_fem_gradient_5tet; depends on nothing.
package vfg5_pkg;

  localparam int VALUE_W  = 32;               // Q16.16 values
  localparam int FRAC_W   = 16;
  localparam int CORNERS  = 8;
  localparam int AXES     = 3;
  localparam int SUM_W    = VALUE_W + 2;      // twice the row sum
  localparam int PROD_W   = SUM_W + VALUE_W;  // row sum times scale
  localparam int RND_W    = PROD_W - FRAC_W - 1;
  localparam int ACC_W    = RND_W + 1;        // rounded plus prior
  localparam int TET_W    = 3;
  localparam int DATA_W   = (CORNERS + AXES) * VALUE_W;
  localparam int RES_W    = AXES * VALUE_W;
  localparam int CFG_IDX_W = 8;

  localparam logic signed [VALUE_W-1:0] SCALE_ONE = VALUE_W'(1) << FRAC_W;
  localparam logic signed [VALUE_W-1:0] VAL_MAX   = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN   = {1'b1, {(VALUE_W-1){1'b0}}};
  // Round half away from zero before an arithmetic shift by FRAC_W+1.
  localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(1) << FRAC_W;
  localparam logic signed [PROD_W-1:0] RND_NEG = RND_POS - PROD_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE = 8'd3;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Tetrahedron codes
  localparam logic [TET_W-1:0] TET_CENTRAL = 3'd0;
  localparam logic [TET_W-1:0] TET_C0      = 3'd1;
  localparam logic [TET_W-1:0] TET_C3      = 3'd2;
  localparam logic [TET_W-1:0] TET_C5      = 3'd3;
  localparam logic [TET_W-1:0] TET_C6      = 3'd4;

  typedef logic [CORNERS-1:0][VALUE_W-1:0] corners_t;
  typedef logic [AXES-1:0][VALUE_W-1:0]    priors_t;

  // Twice the row sum is (p0 + p1) - (n0 + n1).
  typedef struct packed {
    logic signed [VALUE_W-1:0] p0;
    logic signed [VALUE_W-1:0] p1;
    logic signed [VALUE_W-1:0] n0;
    logic signed [VALUE_W-1:0] n1;
  } operand_t;

  function automatic operand_t edge_pair(input logic [VALUE_W-1:0] a,
                                         input logic [VALUE_W-1:0] b);
    operand_t op;
    op.p0 = a;
    op.p1 = a;
    op.n0 = b;
    op.n1 = b;
    return op;
  endfunction

  function automatic operand_t row_operands(input logic [1:0] axis,
                                            input logic [TET_W-1:0] tet,
                                            input corners_t c);
    operand_t op;
    op = '0;
    unique case (tet)
      TET_CENTRAL: begin
        unique case (axis)
          AXIS_X: begin op.p0 = c[1]; op.p1 = c[7]; op.n0 = c[2]; op.n1 = c[4]; end
          AXIS_Y: begin op.p0 = c[2]; op.p1 = c[7]; op.n0 = c[1]; op.n1 = c[4]; end
          AXIS_Z: begin op.p0 = c[4]; op.p1 = c[7]; op.n0 = c[1]; op.n1 = c[2]; end
          default: op = '0;
        endcase
      end
      TET_C0: begin
        unique case (axis)
          AXIS_X: op = edge_pair(c[1], c[0]);
          AXIS_Y: op = edge_pair(c[2], c[0]);
          AXIS_Z: op = edge_pair(c[4], c[0]);
          default: op = '0;
        endcase
      end
      TET_C3: begin
        unique case (axis)
          AXIS_X: op = edge_pair(c[3], c[2]);
          AXIS_Y: op = edge_pair(c[3], c[1]);
          AXIS_Z: op = edge_pair(c[7], c[3]);
          default: op = '0;
        endcase
      end
      TET_C5: begin
        unique case (axis)
          AXIS_X: op = edge_pair(c[5], c[4]);
          AXIS_Y: op = edge_pair(c[7], c[5]);
          AXIS_Z: op = edge_pair(c[5], c[1]);
          default: op = '0;
        endcase
      end
      TET_C6: begin
        unique case (axis)
          AXIS_X: op = edge_pair(c[7], c[6]);
          AXIS_Y: op = edge_pair(c[6], c[4]);
          AXIS_Z: op = edge_pair(c[6], c[2]);
          default: op = '0;
        endcase
      end
      default: op = '0;  // no such tetrahedron: zero row
    endcase
    return op;
  endfunction

  function automatic logic [VALUE_W-1:0] saturate(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-VALUE_W:0] top;
    top = v[ACC_W-1:VALUE_W-1];
    priority if ((&top) || !(|top)) begin
      return v[VALUE_W-1:0];
    end else if (v[ACC_W-1]) begin
      return VAL_MIN;
    end else begin
      return VAL_MAX;
    end
  endfunction

endpackage

// ===== rtl/voxel_fem_gradient_5tet.sv =====
// voxel_fem_gradient_5tet: scaled linear-FEM gradient of one tetrahedron of a voxel.
// Depends on vfg5_pkg (widths, codes, row operand selection, saturation).
//
// Pipeline: an accepted request passes through the input register, then the
//   result register, and a stalled result holds it in the input register.
//   Throughput: one request per cycle; the input register refills in the same
//   cycle the result register advances, and only a stalled result holds it back.
// Reset (rst, synchronous, active high): both pipeline valids clear, scales return
//   to 1.0 and accumulate mode to off. No clearing pass.
module voxel_fem_gradient_5tet (
  input  logic                               clk,
  input  logic                               rst,
  // Input request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // corner_0..corner_7, prior_dx, prior_dy, prior_dz, 32 bits each from bit 0 up
  input  logic [vfg5_pkg::DATA_W-1:0]        s_tdata,
  // tet_index
  input  logic [vfg5_pkg::TET_W-1:0]         s_tuser,
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_dx, out_dy, out_dz, 32 bits each from bit 0 up
  output logic [vfg5_pkg::RES_W-1:0]         m_tdata,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vfg5_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vfg5_pkg::VALUE_W-1:0]       cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are registered; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [vfg5_pkg::AXES-1:0][vfg5_pkg::VALUE_W-1:0] scale;
  logic                                              accumulate_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale           <= {vfg5_pkg::AXES{vfg5_pkg::SCALE_ONE}};
      accumulate_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vfg5_pkg::REG_SCALE_X:    scale[0]        <= cfg_data;
        vfg5_pkg::REG_SCALE_Y:    scale[1]        <= cfg_data;
        vfg5_pkg::REG_SCALE_Z:    scale[2]        <= cfg_data;
        vfg5_pkg::REG_ACCUMULATE: accumulate_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. The result register advances when empty or taken; the
  // input register takes a new request whenever it is empty or advancing, so
  // an empty input register accepts a request while a finished result still waits downstream.
  // ---------------------------------------------------------------------------
  logic                 advance;
  logic                 in_fire;
  logic                 s1_valid;
  logic                 s1_valid_next;
  vfg5_pkg::corners_t   s1_corner;
  vfg5_pkg::priors_t    s1_prior;
  logic [vfg5_pkg::TET_W-1:0] s1_tet;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign in_fire  = s_tvalid && s_tready;

  always_comb begin
    priority if (in_fire) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // Input payload register (no reset)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_corner <= vfg5_pkg::corners_t'(s_tdata[vfg5_pkg::CORNERS*vfg5_pkg::VALUE_W-1:0]);
      s1_prior  <= vfg5_pkg::priors_t'(
                     s_tdata[vfg5_pkg::DATA_W-1:vfg5_pkg::CORNERS*vfg5_pkg::VALUE_W]);
      s1_tet    <= s_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis datapath: pick four corner operands, form twice the row sum,
  // multiply by the scale, round half away from zero dropping FRAC_W+1 bits,
  // optionally add the prior, saturate.
  // ---------------------------------------------------------------------------
  logic [vfg5_pkg::RES_W-1:0] result;

  for (genvar ax = 0; ax < vfg5_pkg::AXES; ax++) begin : g_axis
    vfg5_pkg::operand_t                     op;
    logic signed [vfg5_pkg::SUM_W-1:0]      sum2;
    logic signed [vfg5_pkg::PROD_W-1:0]     prod;
    logic signed [vfg5_pkg::PROD_W-1:0]     biased;
    logic signed [vfg5_pkg::RND_W-1:0]      rnd;
    logic signed [vfg5_pkg::ACC_W-1:0]      acc;
    logic signed [vfg5_pkg::VALUE_W-1:0]    scl;
    logic signed [vfg5_pkg::VALUE_W-1:0]    pri;

    assign scl = scale[ax];
    assign pri = s1_prior[ax];

    always_comb begin
      op     = vfg5_pkg::row_operands(2'(ax), s1_tet, s1_corner);
      sum2   = (vfg5_pkg::SUM_W'(op.p0) + vfg5_pkg::SUM_W'(op.p1))
             - (vfg5_pkg::SUM_W'(op.n0) + vfg5_pkg::SUM_W'(op.n1));
      prod   = sum2 * scl;
      biased = prod + (prod[vfg5_pkg::PROD_W-1] ? vfg5_pkg::RND_NEG : vfg5_pkg::RND_POS);
      rnd    = biased[vfg5_pkg::PROD_W-1:vfg5_pkg::FRAC_W+1];
      acc    = vfg5_pkg::ACC_W'(rnd)
             + (accumulate_mode ? vfg5_pkg::ACC_W'(pri) : vfg5_pkg::ACC_W'(0));
    end

    assign result[ax*vfg5_pkg::VALUE_W +: vfg5_pkg::VALUE_W] = vfg5_pkg::saturate(acc);
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Reset empties both stages.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !m_tvalid))
    else $error("pipeline not empty after reset");

  // An accepted request always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted request lost");

  // A full input stage behind a stalled result must not take a new request.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input stage overrun while result stalled");

  // A zero row in overwrite mode yields an all-zero result.
  a_zero_row: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && (s1_tet > vfg5_pkg::TET_C6) && !accumulate_mode)
      |=> (m_tdata == '0))
    else $error("invalid tetrahedron gave nonzero gradient");

endmodule

// ===== dv/tb_voxel_fem_gradient_5tet.sv =====
// Self-checking bench for voxel_fem_gradient_5tet: streams voxel/tetrahedron requests
// and checks each scaled, rounded and saturated gradient against a local predictor.
// Depends on vfg5_pkg (widths, register and tetrahedron codes) and the RTL top.
module tb_voxel_fem_gradient_5tet;
  timeunit 1ns;
  timeprecision 1ps;

  import vfg5_pkg::*;

  localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES    = 8;     // pipeline is 2 deep, wait a few more
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 244;
  localparam int MAX_REPORTS     = 40;

  // Indexes past the register file; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_ACCUMULATE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
  // Tetrahedron codes with no row behind them.
  localparam logic [TET_W-1:0] TET_VOID_LO = TET_C6 + 1'b1;
  localparam logic [TET_W-1:0] TET_VOID_HI = '1;

  typedef logic [AXES-1:0][VALUE_W-1:0] grad_t;

  // One voxel request; packs straight onto s_tdata as {prior, corner}.
  typedef struct packed {
    logic [TET_W-1:0] tet;
    priors_t          prior;
    corners_t         corner;
  } voxel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata = '0;   // corner_0..corner_7, prior_dx, prior_dy, prior_dz
  logic [TET_W-1:0]     s_tuser = '0;   // tet_index
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [RES_W-1:0]     m_tdata;        // out_dx, out_dy, out_dz
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0]   cfg_data = '0;

  voxel_fem_gradient_5tet uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Local copy of the register file, only touched while the block is idle.
  logic signed [VALUE_W-1:0] mir_scale [AXES];
  bit                        mir_accum;

  voxel_t voxel_q [$];        // requests waiting for the driver
  grad_t  grad_expect_q [$];  // predicted gradients, oldest first
  voxel_t head;
  grad_t  want;

  int  requests_sent = 0;
  int  grads_checked = 0;
  int  cfg_writes    = 0;
  int  settings_run  = 0;
  int  err_cnt       = 0;
  int  quiet_cycles  = 0;
  int  burst_left    = 0;
  int  gap_left      = 0;
  bit  src_idle      = 1'b1;
  logic [15:0] sink_pattern = '1;
  logic [3:0]  sink_phase   = '0;

  // ---------------------------------------------------------------------------
  // Predictor: one gradient component. Twice the row sum is formed exactly, the
  // magnitude is scaled, rounded half away from zero while dividing by 2^17,
  // the sign restored, the prior added, and the total clamped to 32 bits.
  // ---------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] grad_component(input logic [1:0] axis,
                                                        input voxel_t v,
                                                        input logic signed [VALUE_W-1:0] scale,
                                                        input logic signed [VALUE_W-1:0] prior,
                                                        input bit accum);
    logic signed [127:0] cw [CORNERS];
    logic signed [127:0] twice, sc, mag, total;
    bit negative;
    int hi_c, lo_c;
    for (int i = 0; i < CORNERS; i++) cw[i] = $signed(v.corner[i]);
    twice = '0;
    hi_c  = 0;
    lo_c  = 0;
    // Corner tets are one edge difference at weight 1, i.e. 2x at weight 2.
    case (v.tet)
      TET_CENTRAL: begin
        case (axis)
          AXIS_X:  twice = cw[1] - cw[2] - cw[4] + cw[7];
          AXIS_Y:  twice = cw[2] - cw[1] - cw[4] + cw[7];
          default: twice = cw[4] - cw[1] - cw[2] + cw[7];
        endcase
      end
      TET_C0: begin
        lo_c = 0;
        hi_c = (axis == AXIS_X) ? 1 : (axis == AXIS_Y) ? 2 : 4;
      end
      TET_C3: begin
        case (axis)
          AXIS_X:  begin hi_c = 3; lo_c = 2; end
          AXIS_Y:  begin hi_c = 3; lo_c = 1; end
          default: begin hi_c = 7; lo_c = 3; end
        endcase
      end
      TET_C5: begin
        case (axis)
          AXIS_X:  begin hi_c = 5; lo_c = 4; end
          AXIS_Y:  begin hi_c = 7; lo_c = 5; end
          default: begin hi_c = 5; lo_c = 1; end
        endcase
      end
      TET_C6: begin
        case (axis)
          AXIS_X:  begin hi_c = 7; lo_c = 6; end
          AXIS_Y:  begin hi_c = 6; lo_c = 4; end
          default: begin hi_c = 6; lo_c = 2; end
        endcase
      end
      default: twice = '0;  // unused tet codes: all-zero row
    endcase
    twice = twice + 2 * (cw[hi_c] - cw[lo_c]);
    sc = scale;
    negative = (twice < 0) != (sc < 0);
    if (twice < 0) twice = -twice;
    if (sc < 0) sc = -sc;
    mag   = (twice * sc + (128'sd1 <<< FRAC_W)) >>> (FRAC_W + 1);
    total = negative ? -mag : mag;
    if (accum) total = total + prior;
    if (total > VAL_MAX) return VAL_MAX;
    if (total < VAL_MIN) return VAL_MIN;
    return total[VALUE_W-1:0];
  endfunction

  function automatic grad_t predict_gradient(input voxel_t v);
    grad_t g;
    for (int a = 0; a < AXES; a++)
      g[a] = grad_component(2'(a), v, mir_scale[a], $signed(v.prior[a]), mir_accum);
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Field values: extremes, tiny values around the rounding ties, and noise.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return '1;
      4:       return VALUE_W'(1);
      5, 6:    return VALUE_W'($urandom_range(0, 32'h3ffff)) - VALUE_W'(32'h20000);
      7:       return VALUE_W'($urandom_range(0, 32'h3fffff)) << 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return SCALE_ONE;
      1:       return -SCALE_ONE;
      2:       return VAL_MAX;
      3:       return VAL_MIN;
      4:       return '0;
      5:       return '1;
      6, 7:    return VALUE_W'($urandom_range(0, 32'h7ffff)) - VALUE_W'(32'h40000);
      default: return $urandom();
    endcase
  endfunction

  function automatic voxel_t voxel(input corners_t c, input logic [TET_W-1:0] t,
                                   input priors_t p);
    voxel_t v;
    v.corner = c;
    v.tet    = t;
    v.prior  = p;
    return v;
  endfunction

  function automatic voxel_t rand_voxel();
    corners_t c;
    priors_t  p;
    int       pick;
    for (int i = 0; i < CORNERS; i++) c[i] = pick_value();
    for (int a = 0; a < AXES; a++) p[a] = pick_value();
    // Mostly real tetrahedra, now and then an unused code.
    pick = $urandom_range(0, 15);
    if (pick < 14) return voxel(c, TET_W'(pick % 5), p);
    return voxel(c, TET_W'($urandom_range(TET_VOID_LO, TET_VOID_HI)), p);
  endfunction

  // Register write; mirror follows only for indexes that exist.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCALE_X:    mir_scale[AXIS_X] = val;
      REG_SCALE_Y:    mir_scale[AXIS_Y] = val;
      REG_SCALE_Z:    mir_scale[AXIS_Z] = val;
      REG_ACCUMULATE: mir_accum = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // Hold until every queued request has been taken and every result seen.
  task automatic drain();
    while (voxel_q.size() != 0 || grad_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, separated by random gaps while the source
  // idles. Valid is held with stable data until the request is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        grad_expect_q.push_back(predict_gradient(voxel_q[0]));
        voxel_q.delete(0);
        requests_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (voxel_q.size() > 0) begin
          head = voxel_q[0];
          s_tvalid <= 1'b1;
          s_tdata  <= {head.prior, head.corner};
          s_tuser  <= head.tet;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = src_idle ? $urandom_range(1, 6) : 0;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction; ready
  // follows a 16-bit pattern chosen per phase.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (grad_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        end else begin
          want = grad_expect_q.pop_front();
          grads_checked++;
          for (int a = 0; a < AXES; a++) begin
            if (m_tdata[a*VALUE_W +: VALUE_W] !== want[a]) begin
              err_cnt++;
              if (err_cnt <= MAX_REPORTS)
                $display("%0t: axis %0d expected %h actual %h", $time, a, want[a],
                         m_tdata[a*VALUE_W +: VALUE_W]);
            end
          end
        end
      end
      sink_phase = sink_phase + 1'b1;
      m_tready <= sink_pattern[sink_phase];
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, grad_expect_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    corners_t c;
    priors_t  p;
    voxel_t   rv;
    int       split;
    logic [VALUE_W-1:0] sx, sy, sz, acc_word;

    mir_scale[AXIS_X] = SCALE_ONE;
    mir_scale[AXIS_Y] = SCALE_ONE;
    mir_scale[AXIS_Z] = SCALE_ONE;
    mir_accum = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed, reset settings (unit scales, overwrite).
    settings_run++;
    sink_pattern = 16'hb6db;
    p = {VAL_MIN, VAL_MAX, VAL_MAX};  // ignored in overwrite mode
    voxel_q.push_back(voxel('0, TET_CENTRAL, p));
    // Odd corners at max, even at min, then the reverse: largest row sums.
    for (int i = 0; i < CORNERS; i++) c[i] = i[0] ? VAL_MAX : VAL_MIN;
    for (int t = TET_CENTRAL; t <= TET_C6; t++) voxel_q.push_back(voxel(c, TET_W'(t), p));
    for (int i = 0; i < CORNERS; i++) c[i] = i[0] ? VAL_MIN : VAL_MAX;
    for (int t = TET_CENTRAL; t <= TET_C6; t++) voxel_q.push_back(voxel(c, TET_W'(t), p));
    // Half-LSB ties on the central tet, both signs.
    c = '0;
    c[1] = VALUE_W'(1);
    voxel_q.push_back(voxel(c, TET_CENTRAL, p));
    c[1] = '1;
    voxel_q.push_back(voxel(c, TET_CENTRAL, p));
    // Unused tet codes in overwrite mode give zero.
    for (int t = TET_VOID_LO; t <= TET_VOID_HI; t++) begin
      rv = rand_voxel();
      voxel_q.push_back(voxel(rv.corner, TET_W'(t), p));
    end
    rv = rand_voxel();
    voxel_q.push_back(voxel(rv.corner, TET_C0, p));
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Register settings: extremes first, then random.
      if (ph == 0) begin
        sx = VAL_MAX; sy = VAL_MIN; sz = SCALE_ONE; acc_word = 32'hffff_ffff;
      end else if (ph == 1) begin
        sx = -SCALE_ONE; sy = '0; sz = VAL_MIN; acc_word = 32'hffff_fffe;
      end else begin
        sx = pick_scale(); sy = pick_scale(); sz = pick_scale();
        acc_word = $urandom();
      end
      write_reg(REG_SCALE_X, sx);
      write_reg(REG_SCALE_Y, sy);
      write_reg(REG_SCALE_Z, sz);
      write_reg(REG_ACCUMULATE, acc_word);
      // Writes past the register file must not disturb anything.
      if (ph == 0 || $urandom_range(0, 2) == 0) begin
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_SPARE_HI, $urandom());
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
      end
      settings_run++;

      // Idle behavior: one phase runs flat out on both sides.
      if (ph == 2) begin
        src_idle = 1'b0;
        sink_pattern = '1;
      end else begin
        src_idle = $urandom_range(0, 3) != 0;
        sink_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom()) | 16'h0101);
      end

      if (ph == 0) begin
        // Accumulate mode: unused tet passes the saturated prior through.
        p = {VALUE_W'(1), VAL_MIN, VAL_MAX};
        rv = rand_voxel();
        voxel_q.push_back(voxel(rv.corner, TET_VOID_LO, p));
        rv = rand_voxel();
        voxel_q.push_back(voxel(rv.corner, TET_VOID_HI, rv.prior));
        voxel_q.push_back(voxel('0, TET_CENTRAL, p));
        // Big sums with a full-scale prior push past both rails.
        for (int i = 0; i < CORNERS; i++) c[i] = i[0] ? VAL_MAX : VAL_MIN;
        voxel_q.push_back(voxel(c, TET_CENTRAL, {VAL_MAX, VAL_MAX, VAL_MAX}));
        voxel_q.push_back(voxel(c, TET_CENTRAL, {VAL_MIN, VAL_MIN, VAL_MIN}));
        c = '0;
        c[1] = VALUE_W'(1);
        voxel_q.push_back(voxel(c, TET_CENTRAL, '0));
        rv = rand_voxel();
        voxel_q.push_back(voxel(rv.corner, TET_C3, rv.prior));
      end

      // Random requests, with a pause mid-phase until everything has drained.
      split = $urandom_range(ITEMS_PER_PHASE / 4, ITEMS_PER_PHASE * 3 / 4);
      for (int n = 0; n < split; n++) voxel_q.push_back(rand_voxel());
      drain();
      for (int n = split; n < ITEMS_PER_PHASE; n++) voxel_q.push_back(rand_voxel());
      drain();
    end

    $display("Covered %0d voxel requests over %0d register settings (%0d config writes),",
             requests_sent, settings_run, cfg_writes);
    $display("all five tets and the unused codes, both modes, %0d gradients checked.",
             grads_checked);
    if (err_cnt == 0 && grad_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d results never seen", err_cnt, grad_expect_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
